/* rtl/key_matrix_change_detector_core_assert.svh */
// Assertion macros used by the checker file of the key matrix change detector.
`ifndef KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH

// Implication or plain property, checked on every rising clock edge outside reset.
`define KMCD_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define KMCD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/kmcd_pkg.sv */
// Package with the widths, codes and types of the key matrix change detector.
`default_nettype none

package kmcd_pkg;

   localparam int BANK_W     = 4;
   localparam int LEVEL_W    = 16;
   localparam int LVL_IDX_W  = 4;
   localparam int NUM_W      = 5;
   localparam int KEY_NUM_W  = 7;
   localparam int LINE_W     = 5;
   localparam int BASE_W     = 9;
   localparam int KEY_SUM_W  = 10;
   localparam int CSR_IDX_W  = 2;

   localparam logic [NUM_W-1:0] NUM_BANKS_RESET  = 5'd8;
   localparam logic [NUM_W-1:0] NUM_INPUTS_RESET = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BANKS  = 2'd0,
      CSR_NUM_INPUTS = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_FINISH
   } scan_state_type;

   // Sequencer to event buffer.
   typedef struct packed {
      logic                 push;
      logic [KEY_NUM_W-1:0] key_number;
      logic                 pressed;
      logic                 done;
   } seq_to_buf_type;

   // Event buffer back to sequencer.
   typedef struct packed {
      logic push_ok;
      logic done_ok;
   } buf_to_seq_type;

endpackage

`default_nettype wire

/* rtl/kmcd_req_if.sv */
// Channel interfaces for scan samples, key events and register writes.
`default_nettype none

interface kmcd_req_if
   import kmcd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BANK_W-1:0]  bank_index;
   logic [LEVEL_W-1:0] input_levels;

   modport source (output valid, bank_index, input_levels, input ready);
   modport sink   (input valid, bank_index, input_levels, output ready);
endinterface

interface kmcd_rsp_if
   import kmcd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [KEY_NUM_W-1:0] key_number;
   logic                 pressed;
   logic                 last;

   modport source (output valid, key_number, pressed, last, input ready);
   modport sink   (input valid, key_number, pressed, last, output ready);
endinterface

interface kmcd_csr_if
   import kmcd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [NUM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/kmcd_key_map.sv */
// Pressed-key bitmap memory with registered read and per-key valid bits.
`default_nettype none

module kmcd_key_map
   import kmcd_pkg::*;
#(
   parameter int KEY_SLOTS = 128
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(KEY_SLOTS)-1:0] rd_addr,
   output logic                              rd_data,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(KEY_SLOTS)-1:0] wr_addr,
   input  wire logic                         wr_data
);

   logic                 key_mem [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] valid_ff;
   logic                 rd_data_ff;

   // An entry never written since reset reads as key up.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr] & valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/kmcd_evt_buf.sv */
// Event buffer: one pending event that waits for its last marker, and the output register.
`default_nettype none

module kmcd_evt_buf
   import kmcd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_to_buf_type seq_ctl,
   output buf_to_seq_type      buf_stat,
   kmcd_rsp_if.source          rsp_bus
);

   logic                 out_valid_ff, out_valid_in;
   logic [KEY_NUM_W-1:0] out_key_ff, out_key_in;
   logic                 out_pressed_ff, out_pressed_in;
   logic                 out_last_ff, out_last_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [KEY_NUM_W-1:0] pend_key_ff, pend_key_in;
   logic                 pend_pressed_ff, pend_pressed_in;
   logic                 out_free;

   always_comb begin
      out_free         = !out_valid_ff || rsp_bus.ready;
      buf_stat.push_ok = !pend_valid_ff || out_free;
      buf_stat.done_ok = !pend_valid_ff || out_free;

      out_valid_in    = out_valid_ff && !rsp_bus.ready;
      out_key_in      = out_key_ff;
      out_pressed_in  = out_pressed_ff;
      out_last_in     = out_last_ff;
      pend_valid_in   = pend_valid_ff;
      pend_key_in     = pend_key_ff;
      pend_pressed_in = pend_pressed_ff;

      // A newer event proves the pending one is not the last of its item.
      if (seq_ctl.push && buf_stat.push_ok) begin
         if (pend_valid_ff) begin
            out_valid_in   = 1'b1;
            out_key_in     = pend_key_ff;
            out_pressed_in = pend_pressed_ff;
            out_last_in    = 1'b0;
         end
         pend_valid_in   = 1'b1;
         pend_key_in     = seq_ctl.key_number;
         pend_pressed_in = seq_ctl.pressed;
      end else if (seq_ctl.done && pend_valid_ff && out_free) begin
         out_valid_in   = 1'b1;
         out_key_in     = pend_key_ff;
         out_pressed_in = pend_pressed_ff;
         out_last_in    = 1'b1;
         pend_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_key_ff      <= out_key_in;
      out_pressed_ff  <= out_pressed_in;
      out_last_ff     <= out_last_in;
      pend_key_ff     <= pend_key_in;
      pend_pressed_ff <= pend_pressed_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.key_number = out_key_ff;
   assign rsp_bus.pressed    = out_pressed_ff;
   assign rsp_bus.last       = out_last_ff;

endmodule

`default_nettype wire

/* rtl/kmcd_scan_seq.sv */
// Line sequencer: reads each key's stored bit, compares it with the sampled level, writes back a change.
`default_nettype none

module kmcd_scan_seq
   import kmcd_pkg::*;
#(
   parameter int KEY_SLOTS  = 128,
   parameter int MAX_INPUTS = 16,
   parameter int MAX_BANKS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   kmcd_req_if.sink                          req_bus,
   input  wire logic [NUM_W-1:0]             num_banks,
   input  wire logic [NUM_W-1:0]             num_inputs,
   output logic                              map_rd_en,
   output logic [$clog2(KEY_SLOTS)-1:0]      map_rd_addr,
   input  wire logic                         map_rd_data,
   output logic                              map_wr_en,
   output logic [$clog2(KEY_SLOTS)-1:0]      map_wr_addr,
   output logic                              map_wr_data,
   output seq_to_buf_type                    seq_ctl,
   input  wire buf_to_seq_type               buf_stat
);

   localparam int ADDR_W    = $clog2(KEY_SLOTS);
   localparam int LineCapI  = (MAX_INPUTS < LEVEL_W) ? MAX_INPUTS : LEVEL_W;
   localparam logic [NUM_W-1:0]     LineCap  = NUM_W'(LineCapI);
   localparam logic [NUM_W:0]       BankCap  = (NUM_W + 1)'(MAX_BANKS);
   localparam logic [KEY_SUM_W-1:0] SlotCap  = KEY_SUM_W'(KEY_SLOTS);

   scan_state_type       state_ff, state_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [LINE_W-1:0]    lines_ff, lines_in;
   logic [LEVEL_W-1:0]   levels_ff, levels_in;
   logic [LINE_W-1:0]    rd_line_ff, rd_line_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [LINE_W-1:0]    chk_line_ff, chk_line_in;

   logic                 bank_ok;
   logic [LINE_W-1:0]    lines_calc;
   logic [KEY_SUM_W-1:0] rd_key;
   logic [KEY_SUM_W-1:0] chk_key;
   logic                 down;
   logic                 change;

   always_comb begin
      bank_ok = ((NUM_W + 1)'(req_bus.bank_index) < BankCap)
             && (NUM_W'(req_bus.bank_index) < num_banks);
      lines_calc = (num_inputs < LineCap) ? num_inputs : LineCap;

      rd_key  = KEY_SUM_W'(base_ff) + KEY_SUM_W'(rd_line_ff);
      chk_key = KEY_SUM_W'(base_ff) + KEY_SUM_W'(chk_line_ff);
      down    = !levels_ff[chk_line_ff[LVL_IDX_W-1:0]];
      change  = chk_valid_ff && (chk_key < SlotCap) && (down != map_rd_data);

      state_in     = state_ff;
      base_in      = base_ff;
      lines_in     = lines_ff;
      levels_in    = levels_ff;
      rd_line_in   = rd_line_ff;
      chk_valid_in = chk_valid_ff;
      chk_line_in  = chk_line_ff;

      req_bus.ready = 1'b0;
      map_rd_en     = 1'b0;
      map_rd_addr   = rd_key[ADDR_W-1:0];
      map_wr_en     = 1'b0;
      map_wr_addr   = chk_key[ADDR_W-1:0];
      map_wr_data   = down;

      seq_ctl.push       = 1'b0;
      seq_ctl.key_number = chk_key[KEY_NUM_W-1:0];
      seq_ctl.pressed    = down;
      seq_ctl.done       = 1'b0;

      unique case (state_ff)
         SCAN_IDLE: begin
            req_bus.ready = 1'b1;
            // Items for unused banks or with no lines in use are dropped here.
            if (req_bus.valid && bank_ok && (lines_calc != '0)) begin
               base_in      = BASE_W'(req_bus.bank_index) * BASE_W'(num_inputs);
               lines_in     = lines_calc;
               levels_in    = req_bus.input_levels;
               rd_line_in   = '0;
               chk_valid_in = 1'b0;
               state_in     = SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            // Read of the next line overlaps the compare of the current one;
            // both hold while the buffer cannot take the event of a changed key.
            if (!(change && !buf_stat.push_ok)) begin
               if (change) begin
                  map_wr_en    = 1'b1;
                  seq_ctl.push = 1'b1;
               end
               if (rd_line_ff < lines_ff) begin
                  map_rd_en    = 1'b1;
                  chk_valid_in = 1'b1;
                  chk_line_in  = rd_line_ff;
                  rd_line_in   = rd_line_ff + LINE_W'(1);
               end else begin
                  chk_valid_in = 1'b0;
                  state_in     = SCAN_FINISH;
               end
            end
         end
         SCAN_FINISH: begin
            seq_ctl.done = 1'b1;
            if (buf_stat.done_ok) begin
               state_in = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_IDLE;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      lines_ff    <= lines_in;
      levels_ff   <= levels_in;
      rd_line_ff  <= rd_line_in;
      chk_line_ff <= chk_line_in;
   end

endmodule

`default_nettype wire

/* rtl/key_matrix_change_detector_core.sv */
// Top level of the key matrix change detector.
//
//   Channel   Direction  Handshake      Payload
//   req_bus   in         valid / ready  bank_index, input_levels
//   rsp_bus   out        valid / ready  key_number, pressed, last
//   csr_bus   in         valid / ready  index, data (num_banks, num_inputs)
//
// A sample for a bank in use is accepted, then each line goes through the bitmap
// memory's read and compare, the pipe drains and the last event is released. A
// sample for an unused bank is dropped when it is accepted.
// The bitmap reads as all keys up after reset through per-key valid bits, so no
// clearing pass is needed. A stalled result channel holds the line scan once an
// event is pending and the output register is full; results may wait while the
// next sample is taken.
`default_nettype none

module key_matrix_change_detector_core
   import kmcd_pkg::*;
#(
   parameter int KEY_SLOTS  = 128,
   parameter int MAX_INPUTS = 16,
   parameter int MAX_BANKS  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kmcd_req_if.sink   req_bus,
   kmcd_rsp_if.source rsp_bus,
   kmcd_csr_if.sink   csr_bus
);

   localparam int ADDR_W = $clog2(KEY_SLOTS);

   logic [NUM_W-1:0]  num_banks_ff;
   logic [NUM_W-1:0]  num_inputs_ff;

   logic              map_rd_en;
   logic [ADDR_W-1:0] map_rd_addr;
   logic              map_rd_data;
   logic              map_wr_en;
   logic [ADDR_W-1:0] map_wr_addr;
   logic              map_wr_data;
   seq_to_buf_type    seq_ctl;
   buf_to_seq_type    buf_stat;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_banks_ff  <= NUM_BANKS_RESET;
         num_inputs_ff <= NUM_INPUTS_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_NUM_BANKS:  num_banks_ff  <= csr_bus.data;
            CSR_NUM_INPUTS: num_inputs_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   kmcd_scan_seq #(
      .KEY_SLOTS  (KEY_SLOTS),
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_BANKS  (MAX_BANKS)
   ) u_scan_seq (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .num_banks   (num_banks_ff),
      .num_inputs  (num_inputs_ff),
      .map_rd_en   (map_rd_en),
      .map_rd_addr (map_rd_addr),
      .map_rd_data (map_rd_data),
      .map_wr_en   (map_wr_en),
      .map_wr_addr (map_wr_addr),
      .map_wr_data (map_wr_data),
      .seq_ctl     (seq_ctl),
      .buf_stat    (buf_stat)
   );

   kmcd_key_map #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_key_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data)
   );

   kmcd_evt_buf u_evt_buf (
      .clock    (clock),
      .reset    (reset),
      .seq_ctl  (seq_ctl),
      .buf_stat (buf_stat),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

/* rtl/kmcd_checker.sv */
// Port-level checker of the key matrix change detector and its bind.
`default_nettype none

`include "key_matrix_change_detector_core_assert.svh"

module kmcd_checker
   import kmcd_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [KEY_NUM_W-1:0] rsp_key_number,
   input wire logic                 rsp_pressed,
   input wire logic                 rsp_last,
   input wire logic                 csr_ready
);

   // A waiting event must not change under a stalled result channel.
   `KMCD_ASSERT_HOLDS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_number) && $stable(rsp_pressed) && $stable(rsp_last), "rsp item changed while stalled")

   // An event without the last marker means its item is still in progress.
   `KMCD_ASSERT_NEVER(a_no_take_midway, clock, reset, rsp_valid && !rsp_last && req_ready, "new item taken before the last event of the previous one")

   // Register writes are never refused.
   `KMCD_ASSERT_NEVER(a_csr_ready, clock, reset, !csr_ready, "register write refused")

endmodule

bind key_matrix_change_detector_core kmcd_checker u_kmcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_key_number (rsp_bus.key_number),
   .rsp_pressed    (rsp_bus.pressed),
   .rsp_last       (rsp_bus.last),
   .csr_ready      (csr_bus.ready)
);

`default_nettype wire
